// ===== hdl/tppfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator package
// Widths, codes and state type shared by the two-pool page allocator files.
// ----------------------------------------------------------------------------
package tppfa_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned PAGE_NUM_W  = 20;
    localparam int unsigned PAGE_IDX_W  = 16;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned LIMIT_W     = 10;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned WORD_LW     = 5;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 20;

    localparam int unsigned DEF_RAM_PAGES   = 512;
    localparam int unsigned DEF_SWAP_FRAMES = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_LIMIT = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_RAM  = 2'd0,
        OP_ALLOC_SWAP = 2'd1,
        OP_FREE_SWAP  = 2'd2,
        OP_FREE_ALL   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FREED     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_ADDR,
        S_DONE
    } t_state;

endpackage

// ===== hdl/tppfa_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one allocator command word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tppfa_req_if;
    import tppfa_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, op, free_address, input ready);
    modport sink   (input valid, op, free_address, output ready);
endinterface

// ===== hdl/tppfa_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries one allocator result word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tppfa_rsp_if;
    import tppfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;

    modport source (output valid, page_address, status, input ready);
    modport sink   (input valid, page_address, status, output ready);
endinterface

// ===== hdl/tppfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tppfa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/two_pool_page_frame_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-pool page frame allocator
// First-fit allocation of 4 KiB pages from a RAM pool and a swap pool.
// ----------------------------------------------------------------------------
// The block takes one command word on i_req and returns exactly one result
// word on o_rsp. Commands allocate the lowest free RAM page below the page
// limit, allocate the lowest free swap page, free one swap page by address,
// or free every page of both pools. A grant returns the page byte address
// with status granted; an empty pool returns address zero with status
// exhausted; frees return address zero with status free done.
// The used flags live in two RAMs of 32-bit words. One shared scan unit
// reads a word per cycle, masks it against the limit and picks the lowest
// clear bit. An allocation scans the 32-page words below the limit, sets
// the clear flag that it finds and then forms the page byte address.
// Freeing a swap page reads its word, clears the flag and writes the word
// back, and free-all reruns the clearing pass over both bitmaps.
// After reset a clearing pass writes zeros over both bitmaps, one word a
// cycle over as many words as the larger pool has (32 by default);
// i_req stays not ready meanwhile. Configuration writes are taken at any
// time. The result sits in an output register, so a stalled receiver does
// not stop the next command from being accepted and worked on; only the
// hand-off of its result waits.
// ----------------------------------------------------------------------------
module two_pool_page_frame_allocator #(
    parameter int unsigned RAM_PAGES   = tppfa_pkg::DEF_RAM_PAGES,
    parameter int unsigned SWAP_FRAMES = tppfa_pkg::DEF_SWAP_FRAMES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tppfa_req_if.sink                        i_req,
    tppfa_rsp_if.source                      o_rsp,
    input  logic                             i_cfg_we,
    input  logic [tppfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tppfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tppfa_pkg::*;

    // Bitmap geometry: each RAM word holds the used flags of 32 pages.
    localparam int unsigned RAM_ROWS  = (RAM_PAGES + WORD_W - 1) / WORD_W;
    localparam int unsigned SWAP_ROWS = (SWAP_FRAMES + WORD_W - 1) / WORD_W;
    localparam int unsigned MAX_ROWS  = (RAM_ROWS > SWAP_ROWS) ? RAM_ROWS : SWAP_ROWS;
    localparam int unsigned RAM_AW    = (RAM_ROWS > 1) ? $clog2(RAM_ROWS) : 1;
    localparam int unsigned SWAP_AW   = (SWAP_ROWS > 1) ? $clog2(SWAP_ROWS) : 1;
    localparam int unsigned ROW_CW    = $clog2(MAX_ROWS + 1);
    localparam int unsigned LROW_W    = COUNT_W - WORD_LW;

    // Configuration registers.
    logic [PAGE_NUM_W-1:0] r_ram_base;
    logic [PAGE_NUM_W-1:0] r_swap_base;
    logic [LIMIT_W-1:0]    r_ram_limit;

    // Control state.
    t_state                r_state, n_state;
    logic [ROW_CW-1:0]     r_clr, n_clr;
    logic                  r_clr_rsp, n_clr_rsp;
    logic                  r_pend, n_pend;
    logic                  r_out_vld, n_out_vld;

    // Working registers of the current command.
    logic                  r_pool, n_pool;
    logic [COUNT_W-1:0]    r_lim, n_lim;
    logic [ROW_CW-1:0]     r_nrows, n_nrows;
    logic [ROW_CW-1:0]     r_row, n_row;
    logic [ROW_CW-1:0]     r_prow, n_prow;
    logic [PAGE_IDX_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0]     r_res_addr, n_res_addr;
    t_status               r_res_status, n_res_status;
    logic [ADDR_W-1:0]     r_out_addr, n_out_addr;
    t_status               r_out_status, n_out_status;

    // Bitmap RAM ports.
    logic                  ram_we, swap_we;
    logic [RAM_AW-1:0]     ram_waddr, ram_raddr;
    logic [SWAP_AW-1:0]    swap_waddr, swap_raddr;
    logic [WORD_W-1:0]     ram_wdata, ram_rdata, swap_wdata, swap_rdata;

    // Shared scan unit.
    logic [WORD_W-1:0]     scan_word, scan_mask, scan_free, scan_low, scan_set;
    logic [WORD_LW-1:0]    scan_pos;
    logic                  scan_found, scan_empty;
    logic [LROW_W-1:0]     lim_row, prow_ext;

    // Command decode at acceptance.
    t_op                   req_op;
    logic                  req_acc;
    logic [COUNT_W-1:0]    ram_lim_eff, lim_sel;
    logic [COUNT_W:0]      rows_sum;
    logic [PAGE_NUM_W-1:0] free_off;
    logic                  free_hit;
    logic                  clr_last;
    logic [PAGE_NUM_W-1:0] page_num;
    logic [PAGE_NUM_W-1:0] base_sel;

    assign req_op  = t_op'(i_req.op);
    assign req_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.page_address = r_out_addr;
    assign o_rsp.status       = r_out_status;

    // The RAM limit saturates at the pool size; swap always scans the pool.
    assign ram_lim_eff = (COUNT_W'(r_ram_limit) > COUNT_W'(RAM_PAGES)) ?
                         COUNT_W'(RAM_PAGES) : COUNT_W'(r_ram_limit);
    assign lim_sel  = (req_op == OP_ALLOC_SWAP) ? COUNT_W'(SWAP_FRAMES) : ram_lim_eff;
    assign rows_sum = {1'b0, lim_sel} + (COUNT_W + 1)'(WORD_W - 1);

    // A swap free only hits when the address is page aligned and in the pool.
    assign free_off = i_req.free_address[ADDR_W-1:PAGE_SHIFT] - r_swap_base;
    assign free_hit = (i_req.free_address[PAGE_SHIFT-1:0] == '0) &&
                      (free_off < PAGE_NUM_W'(SWAP_FRAMES));

    assign clr_last = (r_clr == ROW_CW'(MAX_ROWS - 1));

    // Scan unit: mask the word read last cycle against the limit, then
    // isolate the lowest clear flag with a two's complement trick.
    assign scan_word = r_pool ? swap_rdata : ram_rdata;
    assign lim_row   = r_lim[COUNT_W-1:WORD_LW];
    assign prow_ext  = LROW_W'(r_prow);

    always_comb begin
        if (lim_row > prow_ext) begin
            scan_mask = '1;
        end else if (lim_row == prow_ext) begin
            scan_mask = (WORD_W'(1) << r_lim[WORD_LW-1:0]) - WORD_W'(1);
        end else begin
            scan_mask = '0;
        end
    end

    assign scan_free = ~scan_word & scan_mask;
    assign scan_low  = scan_free & (~scan_free + WORD_W'(1));
    assign scan_set  = scan_word | scan_low;

    always_comb begin
        scan_pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (scan_low[i]) begin
                scan_pos = scan_pos | WORD_LW'(i);
            end
        end
    end

    assign scan_found = r_pend && (scan_free != '0);
    assign scan_empty = !r_pend && (r_row >= r_nrows);

    // Page address: base plus index, wrapping in the 20-bit page space.
    assign base_sel = r_pool ? r_swap_base : r_ram_base;
    assign page_num = base_sel + PAGE_NUM_W'(r_idx);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = r_clr_rsp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    unique case (req_op) inside
                        OP_ALLOC_RAM, OP_ALLOC_SWAP: n_state = S_SCAN;
                        OP_FREE_SWAP: n_state = free_hit ? S_FREE_RD : S_DONE;
                        OP_FREE_ALL:  n_state = S_CLEAR;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_found) begin
                    n_state = S_ADDR;
                end else if (scan_empty) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_RD: n_state = S_FREE_WR;
            S_FREE_WR: n_state = S_DONE;
            S_ADDR:    n_state = S_DONE;
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and output controls.
    always_comb begin
        n_clr        = r_clr;
        n_clr_rsp    = r_clr_rsp;
        n_pend       = r_pend;
        n_pool       = r_pool;
        n_lim        = r_lim;
        n_nrows      = r_nrows;
        n_row        = r_row;
        n_prow       = r_prow;
        n_idx        = r_idx;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = RAM_AW'(r_prow);
        ram_wdata    = scan_set;
        ram_raddr    = RAM_AW'(r_row);
        swap_we      = 1'b0;
        swap_waddr   = SWAP_AW'(r_prow);
        swap_wdata   = scan_set;
        swap_raddr   = SWAP_AW'(r_row);

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = (r_clr < ROW_CW'(RAM_ROWS));
                swap_we    = (r_clr < ROW_CW'(SWAP_ROWS));
                ram_waddr  = RAM_AW'(r_clr);
                swap_waddr = SWAP_AW'(r_clr);
                ram_wdata  = '0;
                swap_wdata = '0;
                n_clr      = r_clr + ROW_CW'(1);
                if (clr_last) begin
                    n_clr = '0;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_pool       = (req_op == OP_ALLOC_SWAP);
                    n_lim        = lim_sel;
                    n_nrows      = ROW_CW'(rows_sum >> WORD_LW);
                    n_row        = '0;
                    n_pend       = 1'b0;
                    n_idx        = free_off[PAGE_IDX_W-1:0];
                    n_res_addr   = '0;
                    n_res_status = ST_FREED;
                    n_clr        = '0;
                    n_clr_rsp    = (req_op == OP_FREE_ALL);
                end
            end
            S_SCAN: begin
                // Issue the next word while checking the one read last cycle.
                n_pend = (r_row < r_nrows);
                n_prow = r_row;
                if (r_row < r_nrows) begin
                    n_row = r_row + ROW_CW'(1);
                end
                if (scan_found) begin
                    ram_we       = !r_pool;
                    swap_we      = r_pool;
                    n_idx        = PAGE_IDX_W'({r_prow, scan_pos});
                    n_res_status = ST_GRANTED;
                end else if (scan_empty) begin
                    n_res_status = ST_EXHAUSTED;
                end
            end
            S_FREE_RD: begin
                swap_raddr = SWAP_AW'(r_idx[PAGE_IDX_W-1:WORD_LW]);
            end
            S_FREE_WR: begin
                swap_we    = 1'b1;
                swap_waddr = SWAP_AW'(r_idx[PAGE_IDX_W-1:WORD_LW]);
                swap_wdata = swap_rdata & ~(WORD_W'(1) << r_idx[WORD_LW-1:0]);
            end
            S_ADDR: begin
                n_res_addr = {page_num, {PAGE_SHIFT{1'b0}}};
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                end
            end
            default: begin
                n_out_vld = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_base  <= '0;
            r_swap_base <= '0;
            r_ram_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAM_BASE:  r_ram_base  <= i_cfg_data[PAGE_NUM_W-1:0];
                CFG_SWAP_BASE: r_swap_base <= i_cfg_data[PAGE_NUM_W-1:0];
                CFG_RAM_LIMIT: r_ram_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control registers; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_clr_rsp <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_rsp <= n_clr_rsp;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pool       <= n_pool;
        r_lim        <= n_lim;
        r_nrows      <= n_nrows;
        r_row        <= n_row;
        r_prow       <= n_prow;
        r_idx        <= n_idx;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    tppfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_ROWS)
    ) u_ram_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tppfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SWAP_ROWS)
    ) u_swap_map (
        .i_clk   (i_clk),
        .i_we    (swap_we),
        .i_waddr (swap_waddr),
        .i_wdata (swap_wdata),
        .i_raddr (swap_raddr),
        .o_rdata (swap_rdata)
    );
endmodule

// ===== hdl/tppfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the request and response ports of the page allocator.
// ----------------------------------------------------------------------------
module tppfa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [tppfa_pkg::ADDR_W-1:0]     i_rsp_page_address,
    input logic [tppfa_pkg::STATUS_W-1:0]   i_rsp_status
);
    import tppfa_pkg::*;

    // A stalled result word keeps its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_page_address) && $stable(i_rsp_status))
        else $error("response word changed while stalled");

    // Only a grant carries a page address.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_GRANTED) |-> (i_rsp_page_address == '0))
        else $error("non-grant result carries an address");

    // No unused status code is ever delivered.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_GRANTED) || (i_rsp_status == ST_EXHAUSTED) ||
                        (i_rsp_status == ST_FREED))
        else $error("unknown status code");

    // A command occupies the block for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted back to back");
endmodule

bind two_pool_page_frame_allocator tppfa_checker u_tppfa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_page_address (o_rsp.page_address),
    .i_rsp_status       (o_rsp.status)
);
